### hw/rtl/rmms_pkg.sv
package rmms_pkg;

    // Fixed field widths of the sample and result transactions
    localparam int SAMPLE_WIDTH      = 16;
    localparam int IDX_WIDTH         = 16;
    localparam int Q_WIDTH           = 32;
    localparam int FRAC_BITS         = 16;
    localparam int MAX_ITEMS_DEFAULT = 65536;

    // Final arithmetic works modulo 2^64, split into 32-bit halves for the multiplier
    localparam int WORD_W     = 64;
    localparam int HALF_W     = 32;
    localparam int MEAN_ITERS = WORD_W;
    localparam int VAR_ITERS  = WORD_W + 2 * FRAC_BITS;
    localparam int DIV_CNT_W  = $clog2(VAR_ITERS + 1);

    typedef enum logic [3:0] {
        ST_ACCUM,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_MUL4,
        ST_MUL5,
        ST_MEAN_START,
        ST_MEAN_WAIT,
        ST_VAR_START,
        ST_VAR_WAIT,
        ST_SQRT_START,
        ST_SQRT_WAIT,
        ST_OUTPUT
    } rmms_state_t;

    // Multiplier operand pairs
    typedef enum logic [2:0] {
        MUL_N_SQLO,
        MUL_N_SQHI,
        MUL_S_LOLO,
        MUL_S_LOHI,
        MUL_N_N
    } rmms_mul_sel_t;

    // What the variance accumulator does with the registered product
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD_HI,
        ACC_SUB,
        ACC_SUB_HI2,
        ACC_LOAD_M
    } rmms_acc_op_t;

    typedef struct packed {
        logic          accept;
        rmms_mul_sel_t mul_sel;
        rmms_acc_op_t  acc_op;
        logic          div_start;
        logic          div_var;
        logic          mean_load;
        logic          sqrt_start;
        logic          out_load;
    } rmms_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic sqrt_busy;
        logic out_free;
    } rmms_status_t;

endpackage

### hw/rtl/running_min_max_mean_stdev.sv
// The result transaction is registered after the last sample of a run is accepted,
//   following the multiply sequence, two passes of the shared radix-2 divider (mean,
//   then variance) and the bit-serial square root.
// Throughput: one sample per cycle within a run; s_ready is low from the last sample until the result is registered.
// Reset: aresetn (synchronous, active low) clears the run accumulators, FSM and m_valid.
module running_min_max_mean_stdev #(
    parameter int MAX_ITEMS = rmms_pkg::MAX_ITEMS_DEFAULT
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [rmms_pkg::SAMPLE_WIDTH-1:0] s_sample,
    input  logic                                     s_last,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [rmms_pkg::SAMPLE_WIDTH-1:0] m_max_value,
    output logic [rmms_pkg::IDX_WIDTH-1:0]           m_max_index,
    output logic signed [rmms_pkg::SAMPLE_WIDTH-1:0] m_min_value,
    output logic [rmms_pkg::IDX_WIDTH-1:0]           m_min_index,
    output logic signed [rmms_pkg::Q_WIDTH-1:0]      m_mean_q,
    output logic [rmms_pkg::Q_WIDTH-1:0]             m_stdev_q,
    output logic                                     m_overflow
);
    import rmms_pkg::*;

    rmms_cmd_t    cmd;
    rmms_status_t status;

    rmms_ctrl u_ctrl (
        .clk     (aclk),
        .rstn    (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .status  (status),
        .s_ready (s_ready),
        .cmd     (cmd)
    );

    rmms_dp #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .clk         (aclk),
        .rstn        (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_sample    (s_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_max_value (m_max_value),
        .m_max_index (m_max_index),
        .m_min_value (m_min_value),
        .m_min_index (m_min_index),
        .m_mean_q    (m_mean_q),
        .m_stdev_q   (m_stdev_q),
        .m_overflow  (m_overflow)
    );

endmodule

### hw/rtl/rmms_div.sv
module rmms_div #(
    parameter int DIVISOR_W = 2 * ($clog2(rmms_pkg::MAX_ITEMS_DEFAULT + 1))
) (
    input  logic                            clk,
    input  logic                            rstn,
    input  logic                            start,
    input  logic [rmms_pkg::WORD_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0]            divisor,
    input  logic [rmms_pkg::DIV_CNT_W-1:0]  iters,
    output logic                            busy,
    output logic [rmms_pkg::WORD_W-1:0]     quotient
);
    import rmms_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0]    num_reg, num_next;
    logic [WORD_W-1:0]    quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] den_reg, den_next;

    logic [DIVISOR_W:0]   rem_sh;
    logic [DIVISOR_W:0]   rem_diff;
    logic                 fits;

    // One restoring step: bring in the next dividend bit, subtract if it fits
    assign rem_sh   = {rem_reg, num_reg[WORD_W-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign fits     = rem_sh >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = iters;
            num_next  = dividend;
            quo_next  = '0;
            rem_next  = '0;
            den_next  = divisor;
        end else if (busy_reg) begin
            // zeros shift in behind the dividend, extending it for the fraction bits
            num_next  = {num_reg[WORD_W-2:0], 1'b0};
            quo_next  = {quo_reg[WORD_W-2:0], fits};
            rem_next  = fits ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            busy_next = cnt_reg != DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

### hw/rtl/rmms_sqrt.sv
module rmms_sqrt (
    input  logic                        clk,
    input  logic                        rstn,
    input  logic                        start,
    input  logic [rmms_pkg::WORD_W-1:0] radicand,
    output logic                        busy,
    output logic [rmms_pkg::HALF_W-1:0] root
);
    import rmms_pkg::*;

    logic              busy_reg, busy_next;
    logic [WORD_W-1:0] x_reg, x_next;
    logic [WORD_W-1:0] res_reg, res_next;
    logic [WORD_W-1:0] bit_reg, bit_next;
    logic [WORD_W-1:0] trial;

    // Digit-by-digit square root, one result bit per cycle
    assign trial = res_reg + bit_reg;

    always_comb begin
        busy_next = busy_reg;
        x_next    = x_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (start) begin
            busy_next = 1'b1;
            x_next    = radicand;
            res_next  = '0;
            bit_next  = WORD_W'(1) << (WORD_W - 2);
        end else if (busy_reg) begin
            if (x_reg >= trial) begin
                x_next   = x_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next  = bit_reg >> 2;
            busy_next = (bit_reg >> 2) != '0;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk) begin
        x_reg   <= x_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign busy = busy_reg;
    assign root = res_reg[HALF_W-1:0];

endmodule

### hw/rtl/rmms_ctrl.sv
module rmms_ctrl (
    input  logic                   clk,
    input  logic                   rstn,
    input  logic                   s_valid,
    input  logic                   s_last,
    input  rmms_pkg::rmms_status_t status,
    output logic                   s_ready,
    output rmms_pkg::rmms_cmd_t    cmd
);
    import rmms_pkg::*;

    rmms_state_t state_reg, state_next;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= ST_ACCUM;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        cmd            = '0;
        cmd.mul_sel    = MUL_N_SQLO;
        cmd.acc_op     = ACC_HOLD;
        case (state_reg)
            ST_ACCUM: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && s_last) begin
                    state_next = ST_MUL0;
                end
            end
            // n*sumsq - sum^2 modulo 2^64, and n^2, through one 32x32 multiplier
            ST_MUL0: begin
                cmd.mul_sel = MUL_N_SQLO;
                state_next  = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul_sel = MUL_N_SQHI;
                cmd.acc_op  = ACC_LOAD;
                state_next  = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul_sel = MUL_S_LOLO;
                cmd.acc_op  = ACC_ADD_HI;
                state_next  = ST_MUL3;
            end
            ST_MUL3: begin
                cmd.mul_sel = MUL_S_LOHI;
                cmd.acc_op  = ACC_SUB;
                state_next  = ST_MUL4;
            end
            ST_MUL4: begin
                cmd.mul_sel = MUL_N_N;
                cmd.acc_op  = ACC_SUB_HI2;
                state_next  = ST_MUL5;
            end
            ST_MUL5: begin
                cmd.acc_op = ACC_LOAD_M;
                state_next = ST_MEAN_START;
            end
            ST_MEAN_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_VAR_START;
                end
            end
            // mean quotient is captured as the divider restarts on the variance
            ST_VAR_START: begin
                cmd.mean_load = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_var   = 1'b1;
                state_next    = ST_VAR_WAIT;
            end
            ST_VAR_WAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_SQRT_START;
                end
            end
            ST_SQRT_START: begin
                cmd.sqrt_start = 1'b1;
                state_next     = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: begin
                if (!status.sqrt_busy) begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default: begin
                state_next = ST_ACCUM;
            end
        endcase
    end

endmodule

### hw/rtl/rmms_dp.sv
module rmms_dp #(
    parameter int MAX_ITEMS = rmms_pkg::MAX_ITEMS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rstn,
    input  rmms_pkg::rmms_cmd_t                   cmd,
    output rmms_pkg::rmms_status_t                status,
    input  logic signed [rmms_pkg::SAMPLE_WIDTH-1:0] s_sample,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [rmms_pkg::SAMPLE_WIDTH-1:0] m_max_value,
    output logic [rmms_pkg::IDX_WIDTH-1:0]        m_max_index,
    output logic signed [rmms_pkg::SAMPLE_WIDTH-1:0] m_min_value,
    output logic [rmms_pkg::IDX_WIDTH-1:0]        m_min_index,
    output logic signed [rmms_pkg::Q_WIDTH-1:0]   m_mean_q,
    output logic [rmms_pkg::Q_WIDTH-1:0]          m_stdev_q,
    output logic                                  m_overflow
);
    import rmms_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W = SAMPLE_WIDTH + CNT_W;
    localparam int SQ_W  = 2 * SAMPLE_WIDTH + CNT_W - 1;
    localparam int M_W   = 2 * CNT_W;

    // Run accumulators
    logic [CNT_W-1:0]               count_reg, count_next;
    logic signed [SUM_W-1:0]        sum_reg, sum_next;
    logic [SQ_W-1:0]                sq_reg, sq_next;
    logic signed [SAMPLE_WIDTH-1:0] max_reg, max_next;
    logic signed [SAMPLE_WIDTH-1:0] min_reg, min_next;
    logic [IDX_WIDTH-1:0]           max_pos_reg, max_pos_next;
    logic [IDX_WIDTH-1:0]           min_pos_reg, min_pos_next;
    logic                           ovf_reg, ovf_next;

    logic signed [2*SAMPLE_WIDTH-1:0] s_ext;
    logic signed [2*SAMPLE_WIDTH-1:0] sq_full;
    logic                             first;

    assign s_ext   = (2*SAMPLE_WIDTH)'(s_sample);
    assign sq_full = s_ext * s_ext;
    assign first   = count_reg == '0;

    // Accumulate one sample (past MAX_ITEMS only the overflow flag is set), or clear once the result is registered
    always_comb begin
        count_next   = count_reg;
        sum_next     = sum_reg;
        sq_next      = sq_reg;
        max_next     = max_reg;
        min_next     = min_reg;
        max_pos_next = max_pos_reg;
        min_pos_next = min_pos_reg;
        ovf_next     = ovf_reg;
        if (cmd.out_load) begin
            count_next   = '0;
            sum_next     = '0;
            sq_next      = '0;
            max_next     = '0;
            min_next     = '0;
            max_pos_next = '0;
            min_pos_next = '0;
            ovf_next     = 1'b0;
        end else if (cmd.accept) begin
            if (count_reg >= CNT_W'(MAX_ITEMS)) begin
                ovf_next = 1'b1;
            end else begin
                if (first || s_sample > max_reg) begin
                    max_next     = s_sample;
                    max_pos_next = IDX_WIDTH'(count_reg);
                end
                if (first || s_sample < min_reg) begin
                    min_next     = s_sample;
                    min_pos_next = IDX_WIDTH'(count_reg);
                end
                sum_next   = sum_reg + SUM_W'(s_sample);
                sq_next    = sq_reg + SQ_W'(unsigned'(sq_full));
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            count_reg   <= '0;
            sum_reg     <= '0;
            sq_reg      <= '0;
            max_reg     <= '0;
            min_reg     <= '0;
            max_pos_reg <= '0;
            min_pos_reg <= '0;
            ovf_reg     <= 1'b0;
        end else begin
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            sq_reg      <= sq_next;
            max_reg     <= max_next;
            min_reg     <= min_next;
            max_pos_reg <= max_pos_next;
            min_pos_reg <= min_pos_next;
            ovf_reg     <= ovf_next;
        end
    end

    // Magnitude of the sum and 64-bit views of the operands
    logic             neg;
    logic [SUM_W-1:0] sum_u;
    logic [SUM_W-1:0] asum;
    logic [WORD_W-1:0] asum64;
    logic [WORD_W-1:0] sq64;
    logic [HALF_W-1:0] n32;

    assign neg    = sum_reg[SUM_W-1];
    assign sum_u  = unsigned'(sum_reg);
    assign asum   = neg ? (~sum_u + SUM_W'(1)) : sum_u;
    assign asum64 = WORD_W'(asum);
    assign sq64   = WORD_W'(sq_reg);
    assign n32    = HALF_W'(count_reg);

    // Shared 32x32 multiplier with registered product
    logic [HALF_W-1:0] mul_a, mul_b;
    logic [WORD_W-1:0] prod_reg;

    always_comb begin
        mul_a = n32;
        mul_b = sq64[HALF_W-1:0];
        case (cmd.mul_sel)
            MUL_N_SQLO: begin
                mul_a = n32;
                mul_b = sq64[HALF_W-1:0];
            end
            MUL_N_SQHI: begin
                mul_a = n32;
                mul_b = sq64[WORD_W-1:HALF_W];
            end
            MUL_S_LOLO: begin
                mul_a = asum64[HALF_W-1:0];
                mul_b = asum64[HALF_W-1:0];
            end
            MUL_S_LOHI: begin
                mul_a = asum64[HALF_W-1:0];
                mul_b = asum64[WORD_W-1:HALF_W];
            end
            MUL_N_N: begin
                mul_a = n32;
                mul_b = n32;
            end
            default: begin
                mul_a = n32;
                mul_b = n32;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Variance numerator D = n*sumsq - sum^2 (mod 2^64) and divisor n^2
    logic [WORD_W-1:0] d_reg, d_next;
    logic [M_W-1:0]    m_reg, m_next;

    always_comb begin
        d_next = d_reg;
        m_next = m_reg;
        case (cmd.acc_op)
            ACC_HOLD:    d_next = d_reg;
            ACC_LOAD:    d_next = prod_reg;
            ACC_ADD_HI:  d_next = d_reg + {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};
            ACC_SUB:     d_next = d_reg - prod_reg;
            ACC_SUB_HI2: d_next = d_reg - {prod_reg[HALF_W-2:0], {(HALF_W+1){1'b0}}};
            ACC_LOAD_M:  m_next = prod_reg[M_W-1:0];
            default:     d_next = d_reg;
        endcase
    end

    always_ff @(posedge clk) begin
        d_reg <= d_next;
        m_reg <= m_next;
    end

    // Shared divider: mean first, then the scaled variance
    logic [WORD_W-1:0]    div_dividend;
    logic [M_W-1:0]       div_divisor;
    logic [DIV_CNT_W-1:0] div_iters;
    logic                 div_busy;
    logic [WORD_W-1:0]    div_quotient;

    assign div_dividend = cmd.div_var ? d_reg : (asum64 << FRAC_BITS);
    assign div_divisor  = cmd.div_var ? m_reg : M_W'(count_reg);
    assign div_iters    = cmd.div_var ? DIV_CNT_W'(VAR_ITERS) : DIV_CNT_W'(MEAN_ITERS);

    rmms_div #(
        .DIVISOR_W (M_W)
    ) u_div (
        .clk      (clk),
        .rstn     (rstn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .iters    (div_iters),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    logic [Q_WIDTH-1:0] mean_reg;

    always_ff @(posedge clk) begin
        if (cmd.mean_load) begin
            mean_reg <= neg ? (~div_quotient[Q_WIDTH-1:0] + Q_WIDTH'(1))
                            : div_quotient[Q_WIDTH-1:0];
        end
    end

    logic              sqrt_busy;
    logic [HALF_W-1:0] sqrt_root;

    rmms_sqrt u_sqrt (
        .clk      (clk),
        .rstn     (rstn),
        .start    (cmd.sqrt_start),
        .radicand (div_quotient),
        .busy     (sqrt_busy),
        .root     (sqrt_root)
    );

    // Result register
    logic out_valid_reg, out_valid_next;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.out_load) begin
            m_max_value <= max_reg;
            m_max_index <= max_pos_reg;
            m_min_value <= min_reg;
            m_min_index <= min_pos_reg;
            m_mean_q    <= signed'(mean_reg);
            m_stdev_q   <= Q_WIDTH'(sqrt_root);
            m_overflow  <= ovf_reg;
        end
    end

    assign m_valid          = out_valid_reg;
    assign status.div_busy  = div_busy;
    assign status.sqrt_busy = sqrt_busy;
    assign status.out_free  = !out_valid_reg || m_ready;

endmodule

### tb/sv/rmms_result_checker.sv
module rmms_result_checker #(
    parameter int MAX_ITEMS = rmms_pkg::MAX_ITEMS_DEFAULT
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    input  logic                                     s_ready,
    input  logic signed [rmms_pkg::SAMPLE_WIDTH-1:0] s_sample,
    input  logic                                     s_last,
    input  logic                                     m_valid,
    input  logic                                     m_ready,
    input  logic signed [rmms_pkg::SAMPLE_WIDTH-1:0] m_max_value,
    input  logic [rmms_pkg::IDX_WIDTH-1:0]           m_max_index,
    input  logic signed [rmms_pkg::SAMPLE_WIDTH-1:0] m_min_value,
    input  logic [rmms_pkg::IDX_WIDTH-1:0]           m_min_index,
    input  logic signed [rmms_pkg::Q_WIDTH-1:0]      m_mean_q,
    input  logic [rmms_pkg::Q_WIDTH-1:0]             m_stdev_q,
    input  logic                                     m_overflow,
    output int unsigned                              mismatches,
    output int unsigned                              results_due,
    output int unsigned                              results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import rmms_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] max_value;
        logic [IDX_WIDTH-1:0]           max_index;
        logic signed [SAMPLE_WIDTH-1:0] min_value;
        logic [IDX_WIDTH-1:0]           min_index;
        logic signed [Q_WIDTH-1:0]      mean_q;
        logic [Q_WIDTH-1:0]             stdev_q;
        logic                           overflow;
    } run_summary_t;

    // statistics of the run in progress
    int unsigned                    run_len = 0;
    longint                         run_sum = 0;
    longint unsigned                run_sumsq = 0;
    logic signed [SAMPLE_WIDTH-1:0] hi_val = '0;
    logic signed [SAMPLE_WIDTH-1:0] lo_val = '0;
    int unsigned                    hi_pos = 0;
    int unsigned                    lo_pos = 0;
    bit                             run_ovf = 1'b0;

    run_summary_t summary_q[$];
    int unsigned  err_total = 0;
    int unsigned  checked_total = 0;

    task automatic clear_run();
        run_len   = 0;
        run_sum   = 0;
        run_sumsq = 0;
        hi_val    = '0;
        lo_val    = '0;
        hi_pos    = 0;
        lo_pos    = 0;
        run_ovf   = 1'b0;
    endtask

    // samples past the cap only mark the run as overflowed
    task automatic take_sample(input logic signed [SAMPLE_WIDTH-1:0] v);
        if (run_len >= MAX_ITEMS) begin
            run_ovf = 1'b1;
        end else begin
            if (run_len == 0 || v > hi_val) begin
                hi_val = v;
                hi_pos = run_len;
            end
            if (run_len == 0 || v < lo_val) begin
                lo_val = v;
                lo_pos = run_len;
            end
            run_sum   += longint'(v);
            run_sumsq += 64'(longint'(v) * longint'(v));
            run_len++;
        end
    endtask

    // bitwise integer square root, floored
    function automatic logic [31:0] floor_sqrt(input logic [63:0] x);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (64'(trial) * 64'(trial) <= x) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // mean and deviation from the one-pass sums, exact integer math mod 2^64
    function automatic run_summary_t summarize();
        run_summary_t r;
        logic [63:0]  n;
        logic [63:0]  mag_sum;
        logic [63:0]  mean64;
        logic [63:0]  var_num;
        logic [63:0]  n_sq;
        logic [127:0] scaled;
        bit           neg;
        n       = 64'(run_len);
        neg     = run_sum < 0;
        mag_sum = neg ? 64'(-run_sum) : 64'(run_sum);
        mean64  = (mag_sum << FRAC_BITS) / n;
        if (neg) begin
            mean64 = 64'd0 - mean64;
        end
        var_num = n * run_sumsq - mag_sum * mag_sum;
        n_sq    = n * n;
        scaled  = {64'd0, var_num} << (2 * FRAC_BITS);
        r.max_value = hi_val;
        r.max_index = IDX_WIDTH'(hi_pos);
        r.min_value = lo_val;
        r.min_index = IDX_WIDTH'(lo_pos);
        r.mean_q    = mean64[Q_WIDTH-1:0];
        r.stdev_q   = floor_sqrt(64'(scaled / {64'd0, n_sq}));
        r.overflow  = run_ovf;
        return r;
    endfunction

    task automatic check_field(input string label, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            err_total++;
            $display("[%0t] %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, label, want, got);
        end
    endtask

    // watch both channels; results are compared before new samples are folded in
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_run();
            summary_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (summary_q.size() == 0) begin
                    err_total++;
                    $display("[%0t] result transaction with none expected: max=%0d min=%0d",
                             $time, m_max_value, m_min_value);
                end else begin
                    run_summary_t want;
                    want = summary_q.pop_front();
                    checked_total++;
                    check_field("max_value", 64'(want.max_value), 64'(m_max_value));
                    check_field("max_index", 64'(want.max_index), 64'(m_max_index));
                    check_field("min_value", 64'(want.min_value), 64'(m_min_value));
                    check_field("min_index", 64'(want.min_index), 64'(m_min_index));
                    check_field("mean_q", 64'(want.mean_q), 64'(m_mean_q));
                    check_field("stdev_q", 64'(want.stdev_q), 64'(m_stdev_q));
                    check_field("overflow", 64'(want.overflow), 64'(m_overflow));
                end
            end
            if (s_valid && s_ready) begin
                take_sample(s_sample);
                if (s_last) begin
                    summary_q.push_back(summarize());
                    clear_run();
                end
            end
        end
        results_due     <= summary_q.size();
        mismatches      <= err_total;
        results_checked <= checked_total;
    end

endmodule

### tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rmms_pkg::*;

    localparam int RUN_CAP      = MAX_ITEMS_DEFAULT;
    localparam int RANDOM_ITEMS = 1550;
    localparam int HOLD_CYCLES  = 3000;
    localparam int TAIL_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 1_000_000;

    localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = ~S_MIN;

    typedef enum int {
        MIX_FULL,
        MIX_EXTREME,
        MIX_FLAT,
        MIX_NARROW,
        MIX_EDGE
    } sample_mix_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic signed [SAMPLE_WIDTH-1:0] s_sample = '0;
    logic                           s_last = 1'b0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic signed [SAMPLE_WIDTH-1:0] m_max_value;
    logic [IDX_WIDTH-1:0]           m_max_index;
    logic signed [SAMPLE_WIDTH-1:0] m_min_value;
    logic [IDX_WIDTH-1:0]           m_min_index;
    logic signed [Q_WIDTH-1:0]      m_mean_q;
    logic [Q_WIDTH-1:0]             m_stdev_q;
    logic                           m_overflow;

    int unsigned mismatches;
    int unsigned results_due;
    int unsigned results_checked;

    bit          idle_on = 1'b1;
    bit          hold_req = 1'b0;
    int unsigned samples_sent = 0;
    int unsigned runs_sent = 0;
    int unsigned cycle_count = 0;

    running_min_max_mean_stdev #(
        .MAX_ITEMS(RUN_CAP)
    ) u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .s_last     (s_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_max_value(m_max_value),
        .m_max_index(m_max_index),
        .m_min_value(m_min_value),
        .m_min_index(m_min_index),
        .m_mean_q   (m_mean_q),
        .m_stdev_q  (m_stdev_q),
        .m_overflow (m_overflow)
    );

    rmms_result_checker #(
        .MAX_ITEMS(RUN_CAP)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_max_value    (m_max_value),
        .m_max_index    (m_max_index),
        .m_min_value    (m_min_value),
        .m_min_index    (m_min_index),
        .m_mean_q       (m_mean_q),
        .m_stdev_q      (m_stdev_q),
        .m_overflow     (m_overflow),
        .mismatches     (mismatches),
        .results_due    (results_due),
        .results_checked(results_checked)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[%0t] run timed out with %0d results outstanding", $time, results_due);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: random back-pressure while idle_on is set, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !idle_on || ($urandom_range(99) >= 32);
            end
        end
    end

    // one sample transaction, with an optional random gap in front
    task automatic offer_sample(input logic signed [SAMPLE_WIDTH-1:0] v, input bit lst);
        int gap = 0;
        if (idle_on) begin
            while ($urandom_range(99) < 32) gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= v;
        s_last   <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        samples_sent++;
        if (lst) runs_sent++;
    endtask

    // stop sending until every closed run has reported
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
    endtask

    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample(
        input sample_mix_t mix, input logic signed [SAMPLE_WIDTH-1:0] base);
        int small_val;
        case (mix)
            MIX_EXTREME: begin
                case ($urandom_range(4))
                    0: return S_MIN;
                    1: return S_MAX;
                    2: return SAMPLE_WIDTH'(-1);
                    3: return SAMPLE_WIDTH'(0);
                    default: return SAMPLE_WIDTH'(1);
                endcase
            end
            MIX_FLAT: return base;
            MIX_NARROW: begin
                small_val = int'($urandom_range(8)) - 4;
                return SAMPLE_WIDTH'(small_val);
            end
            MIX_EDGE: begin
                if ($urandom_range(1) == 1) return S_MAX - SAMPLE_WIDTH'($urandom_range(15));
                return S_MIN + SAMPLE_WIDTH'($urandom_range(15));
            end
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    task automatic send_run(input int len, input sample_mix_t mix);
        logic signed [SAMPLE_WIDTH-1:0] base;
        base = SAMPLE_WIDTH'($urandom);
        for (int i = 0; i < len; i++) begin
            offer_sample(pick_sample(mix, base), i == len - 1);
        end
    endtask

    // stimulus
    initial begin
        int          dir_vals[21];
        bit          dir_end[21];
        int          run_no;
        int          len;
        int          pick;
        int unsigned random_start;

        // single samples at both rails, ties, extremes with repeats, half-step mean,
        // negative mean truncated toward zero
        dir_vals = '{32767, -32768,
                     5, 5, 5,
                     -32768, 32767, 32767, -32768, 0,
                     3, -7, 10, 10, -7, 2,
                     0, 1,
                     -1, -1, 0};
        dir_end  = '{1, 1,
                     0, 0, 1,
                     0, 0, 0, 0, 1,
                     0, 0, 0, 0, 0, 1,
                     0, 1,
                     0, 0, 1};
        run_no   = 0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_vals[i]) offer_sample(SAMPLE_WIDTH'(dir_vals[i]), dir_end[i]);
        drain();

        // random runs, mostly short
        random_start = samples_sent;
        while (samples_sent - random_start < RANDOM_ITEMS) begin
            run_no++;
            if (run_no == 10) hold_req = 1'b1;
            if (run_no == 25) drain();
            idle_on = !(run_no >= 35 && run_no < 50);
            pick = $urandom_range(99);
            if (pick < 80) len = $urandom_range(12, 1);
            else if (pick < 98) len = $urandom_range(120, 13);
            else len = $urandom_range(400, 121);
            send_run(len, sample_mix_t'($urandom_range(4)));
        end
        idle_on = 1'b1;

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d samples in %0d runs: directed ties and rails, random mixes,",
                 samples_sent, runs_sent);
        $display("a long result hold-off and full drains; %0d results checked.",
                 results_checked);
        if (mismatches == 0 && results_due == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/rmms_pkg.sv
hw/rtl/rmms_div.sv
hw/rtl/rmms_sqrt.sv
hw/rtl/rmms_ctrl.sv
hw/rtl/rmms_dp.sv
hw/rtl/running_min_max_mean_stdev.sv
tb/sv/rmms_result_checker.sv
tb/sv/tb.sv
